// File: rtl/core/gradient_noise_3d_assert.svh
// Assertion macros shared by the checker files.
`ifndef GRADIENT_NOISE_3D_ASSERT_SVH
`define GRADIENT_NOISE_3D_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define GN3_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gradient_noise_3d assertion failed");

// Next-cycle implication, off while reset is high.
`define GN3_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gradient_noise_3d assertion failed");

// Next-cycle implication that also holds across reset.
`define GN3_ASSERT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("gradient_noise_3d assertion failed");

`endif

// File: rtl/core/gn3_pkg.sv
package gn3_pkg;

   // Register stages from accept to result register
   localparam int PIPE_DEPTH = 8;
   localparam int NOISE_W    = 18;
   localparam int CELL_W     = 8;
   localparam int CORNERS    = 8;

   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [3:0]        grad_sel_type;

   localparam logic [7:0] PERM_ROM [256] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
      8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
      8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
      8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
      8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
      8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
      8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
      8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
      8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
      8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
      8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
      8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
      8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,
      8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
      8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,
      8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,
      8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,
      8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,
      8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,
      8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,
      8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180};

   // Hash modulo twelve: quotient by reciprocal 171/2048, exact for 8-bit input
   function automatic grad_sel_type grad_sel(input logic [7:0] h);
      logic [15:0] prod;
      logic [4:0]  quo;
      logic [8:0]  rem;
      prod = 16'(h) * 16'd171;
      quo  = prod[15:11];
      rem  = 9'(h) - 9'(quo) * 9'd12;
      return rem[3:0];
   endfunction

endpackage

// File: rtl/core/gn3_hash.sv
module gn3_hash #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  gn3_pkg::cell_type    cell_x,
   input  gn3_pkg::cell_type    cell_y,
   input  gn3_pkg::cell_type    cell_z,
   input  logic [FRAC_BITS-1:0] frac_x,
   input  logic [FRAC_BITS-1:0] frac_y,
   input  logic [FRAC_BITS-1:0] frac_z,
   output logic [7:0]           hash   [8],
   output logic [FRAC_BITS-1:0] fx_out,
   output logic [FRAC_BITS-1:0] fy_out,
   output logic [FRAC_BITS-1:0] fz_out
);
   import gn3_pkg::*;

   logic [7:0]           a_ff [2];
   cell_type             cx1_ff, cy1_ff, cx2_ff;
   logic [7:0]           b_ff [4];
   logic [7:0]           h_ff [8];
   logic [FRAC_BITS-1:0] f1_ff [3];
   logic [FRAC_BITS-1:0] f2_ff [3];
   logic [FRAC_BITS-1:0] f3_ff [3];

   // Stage 1: look up z corners
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0] <= PERM_ROM[cell_z];
         a_ff[1] <= PERM_ROM[cell_z + 8'd1];
         cx1_ff  <= cell_x;
         cy1_ff  <= cell_y;
         f1_ff[0] <= frac_x;
         f1_ff[1] <= frac_y;
         f1_ff[2] <= frac_z;
      end
   end

   // Stage 2: fold in y, index {y,z}
   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 2; j++) begin
            for (int k = 0; k < 2; k++) begin
               b_ff[j*2+k] <= PERM_ROM[cy1_ff + 8'(j) + a_ff[k]];
            end
         end
         cx2_ff <= cx1_ff;
         f2_ff  <= f1_ff;
      end
   end

   // Stage 3: fold in x, index {x,y,z}
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 2; i++) begin
            for (int jk = 0; jk < 4; jk++) begin
               h_ff[i*4+jk] <= PERM_ROM[cx2_ff + 8'(i) + b_ff[jk]];
            end
         end
         f3_ff <= f2_ff;
      end
   end

   assign hash   = h_ff;
   assign fx_out = f3_ff[0];
   assign fy_out = f3_ff[1];
   assign fz_out = f3_ff[2];

endmodule

// File: rtl/core/gn3_fade.sv
module gn3_fade #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [FRAC_BITS-1:0] frac,
   output logic [FRAC_BITS:0]   fade
);
   import gn3_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int QW = F + 6;
   localparam int PW = 2*F + 8;
   localparam int RW = PW - F;
   localparam logic [2*F:0]   HALF2 = (2*F+1)'(1) << (F-1);
   localparam logic [2*F+1:0] HALF3 = (2*F+2)'(1) << (F-1);
   localparam logic [PW-1:0]  HALFP = PW'(1) << (F-1);
   localparam logic [F:0]     ONE   = (F+1)'(1) << F;

   logic [F:0]           t2_ff, t3_in, t3_ff;
   logic [F-1:0]         f1_ff;
   logic signed [QW-1:0] q_in, q_ff;
   logic signed [RW-1:0] r_in, r_ff;
   logic [F:0]           fade_in, fade_ff;
   logic [2*F:0]         sq;
   logic [2*F+1:0]       cu;
   logic signed [PW-1:0] pr;

   // Stage 1: square, rounded
   always_ff @(posedge clock) begin
      if (en) begin
         t2_ff <= sq[2*F:F];
         f1_ff <= frac;
      end
   end
   assign sq = (2*F+1)'(frac) * (2*F+1)'(frac) + HALF2;

   // Stage 2: cube and the quadratic factor
   assign cu    = (2*F+2)'(t2_ff) * (2*F+2)'(f1_ff) + HALF3;
   assign t3_in = cu[F:0] == '0 ? cu[2*F:F] : cu[2*F:F];
   assign q_in  = QW'(6) * $signed(QW'(t2_ff)) - QW'(15) * $signed(QW'(f1_ff))
                + QW'(10) * $signed(QW'(ONE));
   always_ff @(posedge clock) begin
      if (en) begin
         t3_ff <= t3_in;
         q_ff  <= q_in;
      end
   end

   // Stage 3: final product, rounded
   assign pr   = $signed(PW'(t3_ff)) * PW'(q_ff) + $signed(HALFP);
   assign r_in = RW'(pr >>> F);
   always_ff @(posedge clock) begin
      if (en) r_ff <= r_in;
   end

   // Stage 4: limit to 0..ONE
   always_comb begin
      if (r_ff < 0) fade_in = '0;
      else if (r_ff > $signed(RW'(ONE))) fade_in = ONE;
      else fade_in = r_ff[F:0];
   end
   always_ff @(posedge clock) begin
      if (en) fade_ff <= fade_in;
   end

   assign fade = fade_ff;

endmodule

// File: rtl/core/gn3_blend.sv
module gn3_blend #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [7:0]                 hash [8],
   input  logic [FRAC_BITS-1:0]       fx,
   input  logic [FRAC_BITS-1:0]       fy,
   input  logic [FRAC_BITS-1:0]       fz,
   input  logic [FRAC_BITS:0]         fade_u,
   input  logic [FRAC_BITS:0]         fade_v,
   input  logic [FRAC_BITS:0]         fade_w,
   output logic signed [gn3_pkg::NOISE_W-1:0] noise
);
   import gn3_pkg::*;

   localparam int F   = FRAC_BITS;
   localparam int DW  = F + 3;
   localparam int PW  = DW + F + 2;
   localparam int EW  = DW + 17;
   localparam int RSH = (F > 16) ? F - 16 : 0;
   localparam int LSH = (F < 16) ? 16 - F : 0;
   localparam logic [PW-1:0] HALF  = PW'(1) << (F-1);
   localparam logic [EW-1:0] HALFO = (EW'(1) << RSH) >> 1;
   localparam logic signed [EW-1:0] SAT_HI = EW'(131071);
   localparam logic signed [EW-1:0] SAT_LO = -EW'(131072);
   localparam logic signed [DW-1:0] ONE_S  = DW'(1) << F;

   function automatic logic signed [DW-1:0] lerp_f(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b,
                                                  input logic [F:0] w);
      logic signed [DW:0]   d;
      logic signed [PW-1:0] p;
      d = (DW+1)'(b) - (DW+1)'(a);
      p = $signed(PW'(d)) * $signed(PW'({1'b0, w})) + $signed(HALF);
      return a + DW'(p >>> F);
   endfunction

   function automatic logic signed [DW-1:0] dot_f(input grad_sel_type g,
                                                 input logic signed [DW-1:0] dx,
                                                 input logic signed [DW-1:0] dy,
                                                 input logic signed [DW-1:0] dz);
      logic signed [DW-1:0] r;
      case (g)
         4'd0:    r =  dx + dy;
         4'd1:    r = -dx + dy;
         4'd2:    r =  dx - dy;
         4'd3:    r = -dx - dy;
         4'd4:    r =  dx + dz;
         4'd5:    r = -dx + dz;
         4'd6:    r =  dx - dz;
         4'd7:    r = -dx - dz;
         4'd8:    r =  dy + dz;
         4'd9:    r = -dy + dz;
         4'd10:   r =  dy - dz;
         4'd11:   r = -dy - dz;
         default: r = '0;
      endcase
      return r;
   endfunction

   logic signed [DW-1:0] off [2][3];
   logic signed [DW-1:0] n_ff [8];
   logic signed [DW-1:0] x_ff [4];
   logic signed [DW-1:0] y_ff [2];
   logic signed [DW-1:0] z_ff;
   logic [F:0]           v5_ff, w5_ff, w6_ff;
   logic signed [EW-1:0] scaled;
   logic signed [NOISE_W-1:0] noise_in, noise_ff;

   // Corner offsets: fraction, and fraction minus one
   always_comb begin
      off[0][0] = $signed(DW'(fx));
      off[0][1] = $signed(DW'(fy));
      off[0][2] = $signed(DW'(fz));
      for (int a = 0; a < 3; a++) off[1][a] = off[0][a] - ONE_S;
   end

   // Stage 4: gradient dot products, corner index {x,y,z}
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 8; c++) begin
            n_ff[c] <= dot_f(grad_sel(hash[c]), off[c/4][0], off[(c/2)%2][1], off[c%2][2]);
         end
      end
   end

   // Stage 5: blend along x; hold v and w
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) x_ff[c] <= lerp_f(n_ff[c], n_ff[c+4], fade_u);
         v5_ff <= fade_v;
         w5_ff <= fade_w;
      end
   end

   // Stage 6: blend along y
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 2; c++) y_ff[c] <= lerp_f(x_ff[c], x_ff[c+2], v5_ff);
         w6_ff <= w5_ff;
      end
   end

   // Stage 7: blend along z
   always_ff @(posedge clock) begin
      if (en) z_ff <= lerp_f(y_ff[0], y_ff[1], w6_ff);
   end

   // Stage 8: rescale to 16 fraction bits and saturate
   assign scaled = ((EW'(z_ff) + $signed(HALFO)) >>> RSH) <<< LSH;
   always_comb begin
      if (scaled > SAT_HI) noise_in = NOISE_W'(SAT_HI);
      else if (scaled < SAT_LO) noise_in = NOISE_W'(SAT_LO);
      else noise_in = NOISE_W'(scaled);
   end
   always_ff @(posedge clock) begin
      if (en) noise_ff <= noise_in;
   end

   assign noise = noise_ff;

endmodule

// File: rtl/core/gradient_noise_3d.sv
// Throughput: one point per cycle unless a held result is stalled on rsp; eight
// register stages (three hash lookups, dot products, three blend stages, output
// scaling), with the fade multiplies running beside the hash and dot product stages.
// A stall on rsp with a result held freezes the whole pipeline; req_stall follows it.
// Reset (synchronous) clears only the valid bits; data registers are not reset.
module gradient_noise_3d #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_y,
   input  logic signed [31:0]   req_pos_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [gn3_pkg::NOISE_W-1:0] rsp_noise_value
);
   import gn3_pkg::*;

   localparam int F = FRAC_BITS;

   logic                  adv;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic [7:0]            hash [8];
   logic [F-1:0]          fx3, fy3, fz3;
   logic [F:0]            fu, fv, fw;

   // Advance when the result register is empty or being taken
   assign adv       = !vld_ff[PIPE_DEPTH-1] || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_valid};
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   gn3_hash #(.FRAC_BITS(F)) u_hash (
      .clock  (clock),
      .en     (adv),
      .cell_x (req_pos_x[F +: CELL_W]),
      .cell_y (req_pos_y[F +: CELL_W]),
      .cell_z (req_pos_z[F +: CELL_W]),
      .frac_x (req_pos_x[F-1:0]),
      .frac_y (req_pos_y[F-1:0]),
      .frac_z (req_pos_z[F-1:0]),
      .hash   (hash),
      .fx_out (fx3),
      .fy_out (fy3),
      .fz_out (fz3)
   );

   gn3_fade #(.FRAC_BITS(F)) u_fade_x (
      .clock (clock), .en (adv), .frac (req_pos_x[F-1:0]), .fade (fu));
   gn3_fade #(.FRAC_BITS(F)) u_fade_y (
      .clock (clock), .en (adv), .frac (req_pos_y[F-1:0]), .fade (fv));
   gn3_fade #(.FRAC_BITS(F)) u_fade_z (
      .clock (clock), .en (adv), .frac (req_pos_z[F-1:0]), .fade (fw));

   gn3_blend #(.FRAC_BITS(F)) u_blend (
      .clock  (clock),
      .en     (adv),
      .hash   (hash),
      .fx     (fx3),
      .fy     (fy3),
      .fz     (fz3),
      .fade_u (fu),
      .fade_v (fv),
      .fade_w (fw),
      .noise  (rsp_noise_value)
   );

endmodule

// File: rtl/core/gn3_check.sv
`include "gradient_noise_3d_assert.svh"

module gn3_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [17:0] rsp_noise_value
);

   // A result held under stall keeps its value
   `GN3_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_noise_value))
   // Input is stalled only by a stalled, full result register
   `GN3_ASSERT_IMP(a_stall_cause, req_stall, rsp_valid && rsp_stall)
   // Reset empties the pipeline
   `GN3_ASSERT_RST(a_reset_empty, reset, !rsp_valid)
   // Handshake outputs are always driven to known values out of reset
   `GN3_ASSERT_IMP(a_ctrl_known, 1'b1, !$isunknown({rsp_valid, req_stall}))

endmodule

bind gradient_noise_3d gn3_check u_check (.*);
